/* rtl/msr_pkg.sv */
// Package of shared constants and types for the multi-channel sonar ranger.
package msr_pkg;

	localparam int NUM_CHANNELS = 5;
	localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CH_W         = 3;
	localparam int TIME_W       = 32;
	localparam int TIMEOUT_W    = 20;
	localparam int SPEED_W      = 10;
	localparam int DIST_W       = 30;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 20;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 2'd1;

	localparam logic             KIND_EDGE     = 1'b0;
	localparam logic             KIND_UPDATE   = 1'b1;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd30000;
	localparam logic [SPEED_W-1:0]   SPEED_RST   = 10'd343;
	localparam logic [IDX_W-1:0]     LAST_IDX    = IDX_W'(NUM_CHANNELS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DRAIN,
		ST_EMIT
	} msr_state_t;

	typedef struct packed {
		logic             issue;
		logic             fresh;
		logic [IDX_W-1:0] idx;
	} msr_dist_req_t;

	typedef struct packed {
		logic              wr;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] dist_um;
	} msr_dist_res_t;

endpackage

/* rtl/msr_dist_unit.sv */
// Shared distance unit: timeout compare and width-by-speed product, registered.
module msr_dist_unit
	import msr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  msr_dist_req_t        req,
	input  logic [TIME_W-1:0]    width,
	input  logic [SPEED_W-1:0]   speed,
	input  logic [TIMEOUT_W-1:0] timeout,
	output msr_dist_res_t        res
);

	logic              below;
	logic [DIST_W-1:0] prod;
	logic [DIST_W-1:0] dist_calc;
	logic              wr_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [DIST_W-1:0] dist_s1;

	assign below     = width < TIME_W'(timeout);
	assign prod      = DIST_W'(width[TIMEOUT_W-1:0]) * DIST_W'(speed);
	assign dist_calc = below ? {1'b0, prod[DIST_W-1:1]} : '1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1   <= 1'b0;
			idx_s1  <= '0;
			dist_s1 <= '0;
		end else begin
			wr_s1   <= req.issue && req.fresh;
			idx_s1  <= req.idx;
			dist_s1 <= dist_calc;
		end
	end

	assign res.wr      = wr_s1;
	assign res.idx     = idx_s1;
	assign res.dist_um = dist_s1;

endmodule

/* rtl/multi_sonar_echo_ranger.sv */
// Top level of the multi-channel sonar ranger: echo timing, update sequencer and results.
// An echo edge transaction gives no result.
// An update walks the channels one per cycle through the shared distance unit, then
// passes through a drain state and offers one result per channel.
// The input is not ready from the update until its last result transaction.
// Reset is asynchronous and returns every register to its reset value at once.
module multi_sonar_echo_ranger
	import msr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  logic [CH_W-1:0]       channel,
	input  logic                  echo_level,
	input  logic [TIME_W-1:0]     now_us,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CH_W-1:0]       out_channel,
	output logic signed [DIST_W-1:0] distance_um,
	output logic [TIME_W-1:0]     sequence_res,
	output logic [TIME_W-1:0]     timestamp_us,
	output logic [CH_W-1:0]       fire_channel,
	output logic                  last
);

	msr_state_t           state_q, state_d;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [SPEED_W-1:0]   speed_q;
	logic [TIME_W-1:0]    echo_start_q [NUM_CHANNELS];
	logic [TIME_W-1:0]    echo_width_q [NUM_CHANNELS];
	logic                 start_seen_q [NUM_CHANNELS];
	logic                 fresh_q      [NUM_CHANNELS];
	logic [DIST_W-1:0]    distance_q   [NUM_CHANNELS];
	logic [TIME_W-1:0]    update_time_q;
	logic [TIME_W-1:0]    update_count_q;
	logic [CH_W-1:0]      turn_q;
	logic [CH_W-1:0]      fire_q;
	logic [CH_W-1:0]      fire_next;
	logic                 in_fire;
	logic                 out_fire;
	logic                 edge_ok;
	logic [IDX_W-1:0]     edge_idx;
	msr_dist_req_t        req;
	msr_dist_res_t        res;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (state_q == ST_EMIT);
	assign out_fire  = out_valid && out_ready;
	assign edge_ok   = 32'(channel) < 32'(NUM_CHANNELS);
	assign edge_idx  = IDX_W'(channel);
	assign fire_next = (32'(turn_q) < 32'(NUM_CHANNELS)) ? turn_q : '0;

	assign req.issue = (state_q == ST_CALC);
	assign req.fresh = fresh_q[idx_q];
	assign req.idx   = idx_q;

	msr_dist_unit u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.width   (echo_width_q[idx_q]),
		.speed   (speed_q),
		.timeout (timeout_q),
		.res     (res)
	);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && kind == KIND_UPDATE) begin
					state_d = ST_CALC;
					idx_d   = '0;
				end
			end
			ST_CALC: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
				idx_d   = '0;
			end
			ST_EMIT: begin
				if (out_fire) begin
					if (idx_q == LAST_IDX) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			speed_q   <= SPEED_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_TIMEOUT) begin
				timeout_q <= cfg_wdata;
			end else if (cfg_index == REG_SPEED) begin
				speed_q <= cfg_wdata[SPEED_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				echo_start_q[i] <= '0;
				echo_width_q[i] <= '0;
				start_seen_q[i] <= 1'b0;
				fresh_q[i]      <= 1'b0;
				distance_q[i]   <= '1;
			end
			update_time_q  <= '0;
			update_count_q <= '0;
			turn_q         <= '0;
			fire_q         <= '0;
		end else begin
			if (in_fire && kind == KIND_EDGE && edge_ok) begin
				if (echo_level) begin
					echo_start_q[edge_idx] <= now_us;
					start_seen_q[edge_idx] <= 1'b1;
				end else if (start_seen_q[edge_idx]) begin
					echo_width_q[edge_idx] <= now_us - echo_start_q[edge_idx];
					fresh_q[edge_idx]      <= 1'b1;
				end
			end
			if (in_fire && kind == KIND_UPDATE) begin
				update_time_q  <= now_us;
				update_count_q <= update_count_q + 1'b1;
				fire_q         <= fire_next;
				turn_q         <= (32'(fire_next) + 1 >= NUM_CHANNELS) ? '0 :
					fire_next + 1'b1;
			end
			if (req.issue) begin
				fresh_q[idx_q] <= 1'b0;
			end
			if (res.wr) begin
				distance_q[res.idx] <= res.dist_um;
			end
		end
	end

	assign out_channel  = CH_W'(idx_q);
	assign distance_um  = distance_q[idx_q];
	assign sequence_res = update_count_q;
	assign timestamp_us = update_time_q;
	assign fire_channel = fire_q;
	assign last         = (idx_q == LAST_IDX);

	a_update_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == KIND_UPDATE) |=> !in_ready)
		else $error("input still ready after an update transaction");

	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> in_ready)
		else $error("input not ready after the final result transaction");

	a_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		res.wr |-> (state_q == ST_CALC || state_q == ST_DRAIN))
		else $error("distance written outside the channel walk");

	a_no_result_while_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("result offered while input is ready");

endmodule
